// ===== design/sspf_pkg.sv =====
// ----------------------------------------------------------------------------
// sspf_pkg
// shared types and constants of the soft-start pwm driver with fault count
// ----------------------------------------------------------------------------
package sspf_pkg;

  typedef enum logic [1:0] {
    CmdSlowTick = 2'd0,
    CmdSlotTick = 2'd1,
    CmdArm      = 2'd2
  } cmd_e;

  localparam logic [14:0] FaultCap     = 15'd30000;
  localparam logic [14:0] FaultBlock   = 15'd10;
  localparam logic [31:0] CheckMinDuty = 32'd20;
  localparam int unsigned CheckOffset  = 2;
  localparam logic [15:0] RampMask     = 16'h0003;
  localparam logic [15:0] BlankMask    = 16'h00FF;
  localparam int unsigned DutyReset    = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  run_mode;
    logic [15:0] target_level;
    logic        out_sense;
    logic        diag_level;
    logic [7:0]  delay_value;
  } item_t;

  typedef struct packed {
    logic        pwm_out;
    logic [15:0] duty_level;
    logic [14:0] fault_total;
    logic        output_blocked;
  } result_t;

endpackage

// ===== design/soft_start_pwm_with_fault_count.sv =====
// ----------------------------------------------------------------------------
// soft_start_pwm_with_fault_count
// soft-start pwm driver for one load switch with saturating load-fault count
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with command, run mode, target
//   level, output sense, diagnostic level and delay value; an item is taken
//   at a clock edge with in_valid_i high and in_stall_o low
//   command 0 is the slow tick, 1 the pwm slot tick, 2 arms the blanking
//   delay; code 3 changes nothing and reports the present state
//   output channel: out_valid_o / out_stall_i, one result per item with the
//   drive level, duty level, fault total and output-blocked flag
//   path: a taken item waits in the input register, then the state update
//   writes its result into the result register, which drives the outputs
//   throughput: one item per cycle while the output is not stalled, with the
//   state update done between the input register and the result register
//   receiver stall: the result register holds; the input register still
//   takes an item while the result register is empty or draining, so the
//   input stalls only when both stages are full and the output is stalled
//   reset: asynchronous, active low; duty starts at five, all counters,
//   blanking and drive level at zero, both stages empty
// ----------------------------------------------------------------------------
module soft_start_pwm_with_fault_count import sspf_pkg::*; #(
  parameter int unsigned SLOT_BITS = 8,
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  run_mode_i,
  input  logic [15:0] target_level_i,
  input  logic        out_sense_i,
  input  logic        diag_level_i,
  input  logic [7:0]  delay_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pwm_out_o,
  output logic [15:0] duty_level_o,
  output logic [14:0] fault_total_o,
  output logic        output_blocked_o
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_ready;
  logic    advance;
  result_t step_result;
  result_t out_result;

  assign in_item.command      = command_i;
  assign in_item.run_mode     = run_mode_i;
  assign in_item.target_level = target_level_i;
  assign in_item.out_sense    = out_sense_i;
  assign in_item.diag_level   = diag_level_i;
  assign in_item.delay_value  = delay_value_i;

  // the held item updates the state exactly when it moves into the result register
  assign advance = held_valid && out_ready;

  sspf_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .item_i   (in_item),
    .valid_o  (held_valid),
    .advance_i(advance),
    .item_o   (held_item)
  );

  sspf_core #(
    .SLOT_BITS(SLOT_BITS),
    .DUTY_BITS(DUTY_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (held_item),
    .result_o(step_result)
  );

  sspf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (held_valid),
    .ready_o (out_ready),
    .result_i(step_result),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .result_o(out_result)
  );

  assign pwm_out_o        = out_result.pwm_out;
  assign duty_level_o     = out_result.duty_level;
  assign fault_total_o    = out_result.fault_total;
  assign output_blocked_o = out_result.output_blocked;

endmodule

// ===== design/sspf_in_reg.sv =====
// ----------------------------------------------------------------------------
// sspf_in_reg
// input register stage, takes one item per cycle while empty or when the next stage moves
// ----------------------------------------------------------------------------
module sspf_in_reg import sspf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // free when empty or when the held item moves on this cycle
  assign stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/sspf_core.sv =====
// ----------------------------------------------------------------------------
// sspf_core
// driver state and its update for one item, result taken from the new state
// ----------------------------------------------------------------------------
module sspf_core import sspf_pkg::*; #(
  parameter int unsigned SLOT_BITS = 8,
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam logic [DUTY_BITS-1:0] DutyInit = DUTY_BITS'(DutyReset);
  localparam logic [DUTY_BITS-1:0] DutyOff  = DUTY_BITS'(CheckOffset);

  logic [15:0]          tick_q, tick_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic [7:0]           blank_q, blank_d;
  logic [14:0]          fault_q, fault_d;
  logic                 drive_q, drive_d;

  logic [31:0]          goal_ext;
  logic [DUTY_BITS-1:0] goal;
  logic [31:0]          duty_ext;
  logic [31:0]          slot_ext;
  logic [31:0]          check_ext;
  logic [31:0]          duty_out_ext;

  assign goal_ext     = 32'(item_i.target_level >> 2);
  assign goal         = goal_ext[DUTY_BITS-1:0];
  assign duty_ext     = 32'(duty_q);
  assign slot_ext     = 32'(slot_d);
  assign check_ext    = 32'(duty_q - DutyOff);
  assign duty_out_ext = 32'(duty_d);

  always_comb begin
    tick_d  = tick_q;
    duty_d  = duty_q;
    slot_d  = slot_q;
    blank_d = blank_q;
    fault_d = fault_q;
    drive_d = drive_q;
    case (cmd_e'(item_i.command))
      CmdSlowTick: begin
        tick_d = tick_q + 16'd1;
        if ((tick_d & BlankMask) == 16'd0 && blank_q != 8'd0) begin
          blank_d = blank_q - 8'd1;
        end
        if ((tick_d & RampMask) == 16'd0) begin
          if (!item_i.run_mode[0]) begin
            // ramp down, stop at zero
            if (duty_q != '0) begin
              duty_d = duty_q - DUTY_BITS'(1);
            end
          end else if (duty_q < goal) begin
            duty_d = duty_q + DUTY_BITS'(1);
          end else if (duty_q > goal) begin
            duty_d = duty_q - DUTY_BITS'(1);
          end
        end
      end
      CmdSlotTick: begin
        slot_d = slot_q + SLOT_BITS'(1);
        // load check two slots before the falling edge, once blanking is over
        if (blank_q == 8'd0 && duty_ext > CheckMinDuty && slot_ext == check_ext &&
            item_i.out_sense && !item_i.diag_level && fault_q < FaultCap) begin
          fault_d = fault_q + 15'd1;
        end
        if (fault_d < FaultBlock) begin
          drive_d = slot_ext < duty_ext;
        end else begin
          drive_d = 1'b0;
        end
      end
      CmdArm: begin
        blank_d = item_i.delay_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= 16'd0;
      duty_q  <= DutyInit;
      slot_q  <= '0;
      blank_q <= 8'd0;
      fault_q <= 15'd0;
      drive_q <= 1'b0;
    end else if (step_i) begin
      tick_q  <= tick_d;
      duty_q  <= duty_d;
      slot_q  <= slot_d;
      blank_q <= blank_d;
      fault_q <= fault_d;
      drive_q <= drive_d;
    end
  end

  assign result_o.pwm_out        = drive_d;
  assign result_o.duty_level     = duty_out_ext[15:0];
  assign result_o.fault_total    = fault_d;
  assign result_o.output_blocked = fault_d >= FaultBlock;

endmodule

// ===== design/sspf_out_reg.sv =====
// ----------------------------------------------------------------------------
// sspf_out_reg
// result register, holds a result while the receiver stalls
// ----------------------------------------------------------------------------
module sspf_out_reg import sspf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t result_i,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== tb/sv/soft_start_pwm_with_fault_count_tb.sv =====
// ----------------------------------------------------------------------------
// soft_start_pwm_with_fault_count_tb
// self-checking bench for the soft-start pwm driver with load-fault count
//
// A table of directed items runs first: reset state, field extremes, every
// command, the unused code and the ramp in both directions. Random traffic
// follows. Most of it steers the driver into fault checks: ramp the duty
// above twenty, clear the blanking delay, then walk the slot counter and the
// duty up in lock step so that the slot keeps reaching the check slot. Short
// bursts of unconstrained noise are mixed in. A tail then forces a fault at
// every check so that the count passes the blocking level.
// Every result is compared field by field with a bench-side model of the
// driver state. Both channels idle at random outside a quiet stretch.
// ----------------------------------------------------------------------------
module soft_start_pwm_with_fault_count_tb;
  import sspf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned NumDirected = 22;
  localparam int unsigned RandomItems = 1420;
  // fault count held below the blocking level for this many random items
  localparam int unsigned CapUntil    = 1200;
  localparam int unsigned TailItems   = 380;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 8;
  // about 1850 items; idling and stalls add well under half again
  localparam int unsigned CycleLimit  = 50_000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  mode;
    logic [15:0] target;
    logic        sense;
    logic        diag;
    logic [7:0]  delay;
    bit          typed;
    result_t     res;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CmdSlowTick;
  logic [1:0]  run_mode_i = 2'd0;
  logic [15:0] target_level_i = 16'd0;
  logic        out_sense_i = 1'b0;
  logic        diag_level_i = 1'b0;
  logic [7:0]  delay_value_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        pwm_out_o;
  logic [15:0] duty_level_o;
  logic [14:0] fault_total_o;
  logic        output_blocked_o;

  // bench copy of the driver state, advanced once per accepted item
  logic [15:0] pred_tick   = 16'd0;
  logic [15:0] pred_duty   = 16'(DutyReset);
  logic [7:0]  pred_slot   = 8'd0;
  logic [7:0]  pred_blank  = 8'd0;
  logic [14:0] pred_faults = 15'd0;
  logic        pred_drive  = 1'b0;

  result_t     pending_status [$];
  step_row_t   directed [NumDirected];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  // direction of the fault-hunting duty sweep
  bit          climbing = 1'b1;

  soft_start_pwm_with_fault_count dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .run_mode_i      (run_mode_i),
    .target_level_i  (target_level_i),
    .out_sense_i     (out_sense_i),
    .diag_level_i    (diag_level_i),
    .delay_value_i   (delay_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pwm_out_o       (pwm_out_o),
    .duty_level_o    (duty_level_o),
    .fault_total_o   (fault_total_o),
    .output_blocked_o(output_blocked_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // advances the bench state by one item and returns the status it reports
  function automatic result_t compute_pwm_status(input item_t it);
    result_t     st;
    logic [15:0] goal;
    logic [15:0] aim;
    case (it.command)
      CmdSlowTick: begin
        pred_tick = pred_tick + 16'd1;
        if ((pred_tick & BlankMask) == 16'd0 && pred_blank != 8'd0) begin
          pred_blank = pred_blank - 8'd1;
        end
        if ((pred_tick & RampMask) == 16'd0) begin
          goal = it.target_level >> 2;
          if (!it.run_mode[0]) begin
            // modes 0 and 2 ramp down and stop at zero
            if (pred_duty != 16'd0) begin
              pred_duty = pred_duty - 16'd1;
            end
          end else if (pred_duty < goal) begin
            pred_duty = pred_duty + 16'd1;
          end else if (pred_duty > goal) begin
            pred_duty = pred_duty - 16'd1;
          end
        end
      end
      CmdSlotTick: begin
        pred_slot = pred_slot + 8'd1;
        aim = pred_duty - 16'(CheckOffset);
        if (pred_blank == 8'd0 && pred_duty > CheckMinDuty && {8'h0, pred_slot} == aim &&
            it.out_sense && !it.diag_level && pred_faults < FaultCap) begin
          pred_faults = pred_faults + 15'd1;
        end
        pred_drive = (pred_faults < FaultBlock) && ({8'h0, pred_slot} < pred_duty);
      end
      CmdArm: begin
        pred_blank = it.delay_value;
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase
    st.pwm_out        = pred_drive;
    st.duty_level     = pred_duty;
    st.fault_total    = pred_faults;
    st.output_blocked = (pred_faults >= FaultBlock);
    return st;
  endfunction

  function automatic item_t random_fields();
    item_t it;
    it.command      = 2'($urandom_range(3));
    it.run_mode     = 2'($urandom);
    it.target_level = 16'($urandom);
    it.out_sense    = 1'($urandom);
    it.diag_level   = 1'($urandom);
    it.delay_value  = 8'($urandom);
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it = random_fields();
    // short delays mostly, so that blanking still runs out now and then
    if (it.command == CmdArm && $urandom_range(9) < 7) begin
      it.delay_value = 8'($urandom_range(3));
    end
    return it;
  endfunction

  // picks the next item that moves the driver toward a fault check: clear
  // blanking, sweep the duty between 21 and 257, keep slot at duty-2 or one below it
  function automatic item_t hunt_item(input bit sure_fault);
    item_t       it;
    logic [15:0] aim;
    it  = random_fields();
    aim = pred_duty - 16'(CheckOffset);
    if (pred_duty >= 16'd257) begin
      climbing = 1'b0;
    end else if (pred_duty <= 16'd21) begin
      climbing = 1'b1;
    end
    if (pred_blank != 8'd0) begin
      it.command     = CmdArm;
      it.delay_value = 8'd0;
    end else if (!climbing) begin
      it.command     = CmdSlowTick;
      it.run_mode[0] = 1'b0;
    end else if (pred_duty <= CheckMinDuty || {8'h0, pred_slot} == aim) begin
      // step the duty up; the goal sits far above the sweep range
      it.command            = CmdSlowTick;
      it.run_mode[0]        = 1'b1;
      it.target_level[15:14] = 2'b11;
    end else begin
      it.command = CmdSlotTick;
      if ({8'h0, 8'(pred_slot + 8'd1)} == aim && (sure_fault || $urandom_range(1) == 1)) begin
        it.out_sense  = 1'b1;
        it.diag_level = 1'b0;
      end
    end
    return it;
  endfunction

  // offers one item, waits for it to be taken, then books its expected status
  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input result_t fixed = '0);
    result_t predicted;
    if (!quiet && $urandom_range(99) < 4) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= it.command;
    run_mode_i     <= it.run_mode;
    target_level_i <= it.target_level;
    out_sense_i    <= it.out_sense;
    diag_level_i   <= it.diag_level;
    delay_value_i  <= it.delay_value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = compute_pwm_status(it);
    pending_status.push_back(typed ? fixed : predicted);
  endtask

  task automatic check_status(input result_t got);
    result_t want;
    results_seen++;
    if (pending_status.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result %0d arrived with nothing pending", results_seen);
      end
      return;
    end
    want = pending_status.pop_front();
    if (got.pwm_out !== want.pwm_out || got.duty_level !== want.duty_level ||
        got.fault_total !== want.fault_total || got.output_blocked !== want.output_blocked) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result %0d: expected pwm %0b duty %0d faults %0d blocked %0b", results_seen,
                 want.pwm_out, want.duty_level, want.fault_total, want.output_blocked);
        $display("  got pwm %0b duty %0d faults %0d blocked %0b",
                 got.pwm_out, got.duty_level, got.fault_total, got.output_blocked);
      end
    end
  endtask

  // result side: take results, stall at random outside the quiet stretch
  initial begin : collect
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.pwm_out        = pwm_out_o;
        got.duty_level     = duty_level_o;
        got.fault_total    = fault_total_o;
        got.output_blocked = output_blocked_o;
        check_status(got);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 8);
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    item_t       it;
    int unsigned n;
    int unsigned len;
    bit          hunting;
    logic [15:0] aim;

    // typed rows hold what the reset state makes obvious
    directed = '{
      '{CmdUnused,   2'd3, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1, '{1'b0, 16'd5, 15'd0, 1'b0}},
      '{CmdSlotTick, 2'd0, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 16'd5, 15'd0, 1'b0}},
      '{CmdSlowTick, 2'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b1, '{1'b1, 16'd5, 15'd0, 1'b0}},
      '{CmdSlowTick, 2'd2, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1, '{1'b1, 16'd5, 15'd0, 1'b0}},
      '{CmdSlowTick, 2'd1, 16'hFFFF, 1'b0, 1'b1, 8'h00, 1'b1, '{1'b1, 16'd5, 15'd0, 1'b0}},
      '{CmdSlowTick, 2'd0, 16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 16'd4, 15'd0, 1'b0}},
      '{CmdSlotTick, 2'd3, 16'h0000, 1'b0, 1'b1, 8'h00, 1'b0, '0},
      '{CmdSlotTick, 2'd0, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b0, '0},
      '{CmdSlotTick, 2'd1, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdArm,      2'd0, 16'h0000, 1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{CmdArm,      2'd3, 16'hFFFF, 1'b1, 1'b1, 8'h00, 1'b0, '0},
      '{CmdArm,      2'd2, 16'h5555, 1'b0, 1'b1, 8'h01, 1'b0, '0},
      '{CmdSlowTick, 2'd3, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdSlowTick, 2'd3, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdSlowTick, 2'd3, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdSlowTick, 2'd3, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdSlowTick, 2'd1, 16'h0003, 1'b1, 1'b0, 8'hAA, 1'b0, '0},
      '{CmdSlowTick, 2'd1, 16'h0003, 1'b1, 1'b0, 8'hAA, 1'b0, '0},
      '{CmdSlowTick, 2'd1, 16'h0003, 1'b1, 1'b0, 8'hAA, 1'b0, '0},
      '{CmdSlowTick, 2'd1, 16'h0003, 1'b1, 1'b0, 8'hAA, 1'b0, '0},
      '{CmdUnused,   2'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{CmdSlotTick, 2'd3, 16'hFFFF, 1'b1, 1'b0, 8'hFF, 1'b0, '0}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      it.command      = directed[i].cmd;
      it.run_mode     = directed[i].mode;
      it.target_level = directed[i].target;
      it.out_sense    = directed[i].sense;
      it.diag_level   = directed[i].diag;
      it.delay_value  = directed[i].delay;
      send_item(it, directed[i].typed, directed[i].res);
    end

    // random part: long steering bursts with short noise bursts between them
    n = 0;
    while (n < RandomItems) begin
      hunting = ($urandom_range(99) < 75);
      len = hunting ? $urandom_range(80, 20) : $urandom_range(8, 1);
      repeat (len) begin
        quiet = (n >= 700 && n < 1000);
        it = hunting ? hunt_item(1'b0) : noise_item();
        // keep the output unblocked through the early part
        aim = pred_duty - 16'(CheckOffset);
        if (n < CapUntil && pred_faults >= FaultBlock - 15'd1 && it.command == CmdSlotTick &&
            pred_blank == 8'd0 && pred_duty > CheckMinDuty &&
            {8'h0, 8'(pred_slot + 8'd1)} == aim && it.out_sense && !it.diag_level) begin
          it.diag_level = 1'b1;
        end
        send_item(it);
        if (it.command != CmdUnused) begin
          n++;
        end
      end
    end

    // force a fault at every check so the output ends up blocked
    repeat (TailItems) send_item(hunt_item(1'b1));

    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sspf_pkg.sv
design/sspf_in_reg.sv
design/sspf_core.sv
design/sspf_out_reg.sv
design/soft_start_pwm_with_fault_count.sv
tb/sv/soft_start_pwm_with_fault_count_tb.sv
